// File: rtl/core/swfr_pkg.sv
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared types and constants of the sliding-window frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package swfr_pkg;

  localparam int SEQ_BITS        = 3;
  localparam int SEQ_SPACE       = 8;
  localparam int MAX_FRAME_BYTES = 255;
  localparam int COUNT_BITS      = $clog2(MAX_FRAME_BYTES + 2);

  // Frame status codes.
  localparam logic [1:0] STATUS_CHECKSUM_ERR = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED     = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE    = 2'd2;
  localparam logic [1:0] STATUS_REJECTED     = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_BUFFERED_MODE = 1'b0;
  localparam logic REG_WINDOW_SIZE   = 1'b1;

  typedef struct packed {
    logic                buffered_mode;
    logic [SEQ_BITS-1:0] window_size;
  } swfr_cfg_t;

  typedef struct packed {
    logic take_byte;     // a byte transfer completes this cycle
    logic finish_frame;  // that byte is the last one of its frame
  } swfr_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/swfr_regs.sv
// ----------------------------------------------------------------------------
// swfr_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output swfr_pkg::swfr_cfg_t   cfg
);
  import swfr_pkg::*;

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffered_mode <= 1'b0;
      cfg.window_size   <= SEQ_BITS'(1);
    end else if (wr_en) begin
      case (reg_index)
        REG_BUFFERED_MODE: cfg.buffered_mode <= pwdata[0];
        REG_WINDOW_SIZE:   cfg.window_size   <= pwdata[SEQ_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_BUFFERED_MODE: prdata = {31'd0, cfg.buffered_mode};
      REG_WINDOW_SIZE:   prdata = {{(32-SEQ_BITS){1'b0}}, cfg.window_size};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/swfr_ctrl.sv
// ----------------------------------------------------------------------------
// swfr_ctrl
// Handshake controller: takes bytes and holds a frame result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  input  wire logic            s_tlast,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output swfr_pkg::swfr_cmd_t  cmd
);
  import swfr_pkg::*;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_RESULT  = 1'b1;

  logic state;
  logic state_next;

  // A waiting result leaves in the same cycle that a new byte may enter.
  assign s_tready         = (state == ST_COLLECT) || m_tready;
  assign m_tvalid         = (state == ST_RESULT);
  assign cmd.take_byte    = s_tvalid && s_tready;
  assign cmd.finish_frame = s_tvalid && s_tready && s_tlast;

  always_comb begin
    case (state)
      ST_COLLECT: state_next = cmd.finish_frame ? ST_RESULT : ST_COLLECT;
      ST_RESULT: begin
        if (cmd.finish_frame || !m_tready) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/swfr_datapath.sv
// ----------------------------------------------------------------------------
// swfr_datapath
// Checksum accumulator, receive window with its flag store, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire swfr_pkg::swfr_cmd_t           cmd,
  input  wire swfr_pkg::swfr_cfg_t           cfg,
  input  wire logic [swfr_pkg::SEQ_BITS-1:0] seq_number,
  input  wire logic [7:0]                    data_byte,
  input  wire logic [15:0]                   rx_checksum,
  output logic      [1:0]                    frame_status,
  output logic      [swfr_pkg::SEQ_BITS-1:0] next_expected,
  output logic      [swfr_pkg::SEQ_BITS-1:0] frames_released
);
  import swfr_pkg::*;

  logic [15:0]           running_sum;
  logic [COUNT_BITS-1:0] byte_count;
  logic [SEQ_BITS-1:0]   expected_seq;
  logic [SEQ_SPACE-1:0]  received_flags;

  logic [15:0]           sum_next;
  logic [15:0]           total;
  logic [COUNT_BITS-1:0] count_next;
  logic                  overlong;
  logic [SEQ_BITS-1:0]   window_top;
  logic                  in_window;
  logic [SEQ_SPACE-1:0]  flags_marked;
  logic [SEQ_SPACE-1:0]  flags_slid;
  logic [SEQ_BITS:0]     slide_count;
  logic [1:0]            status_next;
  logic [SEQ_BITS-1:0]   expected_next;
  logic [SEQ_BITS:0]     released_next;
  logic [SEQ_SPACE-1:0]  flags_next;

  assign sum_next   = running_sum + {8'd0, data_byte};
  assign total      = sum_next + {{(16-SEQ_BITS){1'b0}}, seq_number};
  assign count_next = (byte_count <= COUNT_BITS'(MAX_FRAME_BYTES))
                    ? byte_count + 1'b1 : byte_count;
  assign overlong   = count_next > COUNT_BITS'(MAX_FRAME_BYTES);

  // Circular interval [expected_seq, window_top).
  assign window_top = expected_seq + cfg.window_size;
  assign in_window  = ((expected_seq <= seq_number) && (seq_number < window_top))
                   || ((window_top < expected_seq) && (expected_seq <= seq_number))
                   || ((seq_number < window_top) && (window_top < expected_seq));

  // Slide past the run of marked flags that starts at the expected number.
  always_comb begin
    logic                run;
    logic [SEQ_BITS-1:0] pos;
    flags_marked = received_flags;
    flags_marked[seq_number] = 1'b1;
    flags_slid   = flags_marked;
    slide_count  = '0;
    run          = 1'b1;
    for (int i = 0; i < SEQ_SPACE; i++) begin
      pos = expected_seq + SEQ_BITS'(i);
      if (run && flags_marked[pos]) begin
        flags_slid[pos] = 1'b0;
        slide_count     = slide_count + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    status_next   = STATUS_REJECTED;
    expected_next = expected_seq;
    released_next = '0;
    flags_next    = received_flags;
    if (overlong || (total != rx_checksum)) begin
      status_next = STATUS_CHECKSUM_ERR;
    end else if (cfg.buffered_mode) begin
      if (in_window) begin
        if (received_flags[seq_number]) begin
          status_next = STATUS_DUPLICATE;
        end else begin
          status_next   = STATUS_ACCEPTED;
          flags_next    = flags_slid;
          released_next = slide_count;
          expected_next = expected_seq + slide_count[SEQ_BITS-1:0];
        end
      end
    end else if (seq_number == expected_seq) begin
      status_next   = STATUS_ACCEPTED;
      expected_next = expected_seq + 1'b1;
      released_next = (SEQ_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      byte_count     <= '0;
      expected_seq   <= '0;
      received_flags <= '0;
    end else if (cmd.finish_frame) begin
      running_sum    <= '0;
      byte_count     <= '0;
      expected_seq   <= expected_next;
      received_flags <= flags_next;
    end else if (cmd.take_byte) begin
      running_sum <= sum_next;
      byte_count  <= count_next;
    end
  end

  // Result register; the controller's state says when it is valid.
  always_ff @(posedge clk) begin
    if (cmd.finish_frame) begin
      frame_status    <= status_next;
      next_expected   <= expected_next;
      frames_released <= released_next[SEQ_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_frame_receiver.sv
// ----------------------------------------------------------------------------
// sliding_window_frame_receiver
// Sliding-window frame receiver with go-back-N and buffered window modes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, except while a frame result waits untaken.
// Latency: the frame result is valid in the cycle after its last byte.
// While a result waits, input bytes are held off until it is taken; a byte
// may enter in the same cycle that the waiting result leaves.
// Reset (synchronous, active high) clears the window, the flag store, the
// checksum and the registers to go-back-N mode with a window of one.
`default_nettype none

module sliding_window_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input bytes.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // seq_number[2:0], data_byte[10:3],
                                      // rx_checksum[26:11], zero[31:27]
  input  wire logic        s_tlast,   // byte_last
  // Frame results.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // frame_status[1:0], next_expected[4:2],
                                      // frames_released[7:5]
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import swfr_pkg::*;

  swfr_cfg_t           cfg;
  swfr_cmd_t           cmd;
  logic [1:0]          frame_status;
  logic [SEQ_BITS-1:0] next_expected;
  logic [SEQ_BITS-1:0] frames_released;

  swfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  swfr_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .seq_number      (s_tdata[2:0]),
    .data_byte       (s_tdata[10:3]),
    .rx_checksum     (s_tdata[26:11]),
    .frame_status    (frame_status),
    .next_expected   (next_expected),
    .frames_released (frames_released)
  );

  assign m_tdata = {frames_released, next_expected, frame_status};

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding-window frame receiver. Frames are
// streamed in byte by byte with random gaps and output stalls. A predictor
// tracks the window, the flag store and the running checksum and queues the
// expected status of every finished frame. A short table of directed frames
// and register writes comes first, then random phases with fresh settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import swfr_pkg::*;

  // Same packing as m_tdata, highest field first.
  typedef struct packed {
    logic [2:0] frames_released;
    logic [2:0] next_expected;
    logic [1:0] frame_status;
  } frame_result_t;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [2:0]    seq;
    logic [7:0]    data;
    int unsigned   nbytes;
    logic [15:0]   rx;
    bit            typed_exp;
    frame_result_t want;
    logic          reg_sel;
    logic [2:0]    reg_val;
  } stim_row_t;

  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the receiver.
  logic                 mode_q   = 1'b0;
  logic [2:0]           win_q    = 3'd1;
  logic [2:0]           exp_q    = '0;
  logic [SEQ_SPACE-1:0] held_q   = '0;
  logic [15:0]          sum_q    = '0;
  int unsigned          nbytes_q = 0;

  frame_result_t status_q[$];
  stim_row_t     directed_q[$];

  int unsigned errors        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned writes_done   = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  bit          quiet         = 1'b0;

  sliding_window_frame_receiver u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic log_failure(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  // Advances the predicted state by one byte; returns 1 when the byte
  // closes a frame and so produces a status.
  function automatic bit absorb_byte(input logic [2:0] seq, input logic [7:0] data,
                                     input logic last, input logic [15:0] rx,
                                     output frame_result_t res);
    logic [15:0] total;
    int unsigned slid;
    bit          overlong;
    res  = '0;
    slid = 0;
    sum_q = sum_q + 16'(data);
    if (nbytes_q <= MAX_FRAME_BYTES) nbytes_q++;
    if (!last) return 1'b0;
    total    = sum_q + 16'(seq);
    overlong = nbytes_q > MAX_FRAME_BYTES;
    sum_q    = '0;
    nbytes_q = 0;
    if (overlong || total != rx) begin
      res.frame_status = STATUS_CHECKSUM_ERR;
    end else if (mode_q) begin
      // The window holds the win_q numbers starting at exp_q, modulo 8.
      if (3'(seq - exp_q) >= win_q) begin
        res.frame_status = STATUS_REJECTED;
      end else if (held_q[seq]) begin
        res.frame_status = STATUS_DUPLICATE;
      end else begin
        held_q[seq] = 1'b1;
        res.frame_status = STATUS_ACCEPTED;
        for (int i = 0; i < SEQ_SPACE; i++) begin
          if (!held_q[exp_q]) break;
          held_q[exp_q] = 1'b0;
          exp_q++;
          slid++;
        end
      end
    end else if (seq == exp_q) begin
      res.frame_status = STATUS_ACCEPTED;
      exp_q++;
      slid = 1;
    end else begin
      res.frame_status = STATUS_REJECTED;
    end
    res.next_expected   = exp_q;
    res.frames_released = 3'(slid);
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [2:0] seq, input logic [7:0] data, input logic last,
                           input logic [15:0] rx, input bit typed_exp,
                           input frame_result_t want);
    frame_result_t res;
    bit            ok;
    while (!quiet && $urandom_range(0, 99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, rx, data, seq};
    s_tlast  <= last;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    bytes_sent++;
    if (absorb_byte(seq, data, last, rx, res)) status_q.push_back(typed_exp ? want : res);
  endtask

  // Stops sending and waits until every frame status has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [2:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    bit          ok;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {29'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ok = pready;
      @(posedge clk);
    end while (!ok);
    if (reg_sel == REG_BUFFERED_MODE) begin
      mode_q = value[0];
      want   = {31'd0, value[0]};
    end else begin
      win_q = value;
      want  = {29'd0, value};
    end
    writes_done++;
    // Read the register back.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ok       = pready;
      readback = prdata;
      @(posedge clk);
    end while (!ok);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== want)
      log_failure($sformatf("register %0d read %h, expected %h", reg_sel, readback, want));
  endtask

  task automatic send_random_frame();
    int unsigned len;
    int unsigned roll;
    bit          noise;
    logic [2:0]  seq;
    logic [7:0]  payload[$];
    logic [15:0] sum;
    logic [15:0] rx;
    roll  = $urandom_range(0, 99);
    noise = roll < 10;
    if ($urandom_range(0, 199) == 0) len = $urandom_range(250, 260);
    else if (noise) len = $urandom_range(1, 12);
    else len = $urandom_range(1, 6);
    if (noise) seq = 3'($urandom_range(0, 7));
    else if (mode_q) seq = exp_q + 3'($urandom_range(0, win_q));
    else if ($urandom_range(0, 3) == 0) seq = 3'($urandom_range(0, 7));
    else seq = exp_q;
    sum = '0;
    for (int k = 0; k < len; k++) begin
      payload.push_back(8'($urandom_range(0, 255)));
      sum = sum + 16'(payload[k]);
    end
    rx = sum + 16'(seq);
    if (noise) rx = 16'($urandom_range(0, 65535));
    else if ($urandom_range(0, 9) == 0) rx = rx ^ (16'd1 << $urandom_range(0, 15));
    for (int k = 0; k < len; k++) send_byte(seq, payload[k], k == len - 1, rx, 1'b0, '0);
  endtask

  function automatic stim_row_t frame_row(input logic [2:0] seq, input logic [7:0] data,
                                          input int unsigned nbytes, input logic [15:0] rx,
                                          input bit typed_exp = 1'b0,
                                          input logic [1:0] status = STATUS_CHECKSUM_ERR,
                                          input logic [2:0] next_seq = '0,
                                          input logic [2:0] released = '0);
    stim_row_t row;
    row           = '{kind: ROW_FRAME, default: '0};
    row.kind      = ROW_FRAME;
    row.seq       = seq;
    row.data      = data;
    row.nbytes    = nbytes;
    row.rx        = rx;
    row.typed_exp = typed_exp;
    row.want      = '{frames_released: released, next_expected: next_seq,
                      frame_status: status};
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic reg_sel, input logic [2:0] value);
    stim_row_t row;
    row         = '{kind: ROW_WRITE, default: '0};
    row.kind    = ROW_WRITE;
    row.reg_sel = reg_sel;
    row.reg_val = value;
    return row;
  endfunction

  // Output side: random stalls, a long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 34);
    end
  end

  // Handshake signals are stable at the falling edge; a transfer seen here
  // completes at the next rising edge.
  always @(negedge clk) begin : result_check
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (status_q.size() == 0) begin
        log_failure($sformatf("frame result %h with nothing expected", got));
      end else begin
        want = status_q.pop_front();
        if (got.frame_status !== want.frame_status ||
            got.next_expected !== want.next_expected ||
            got.frames_released !== want.frames_released)
          log_failure($sformatf(
            "result %0d: status %0d/%0d next %0d/%0d released %0d/%0d (got/exp)",
            results_seen, got.frame_status, want.frame_status,
            got.next_expected, want.next_expected,
            got.frames_released, want.frames_released));
      end
    end
  end

  initial begin : stimulus
    int unsigned      start_bytes;
    int unsigned      phase;
    int unsigned      nframes;
    logic [2:0]       win;
    logic [2:0]       edge_wins[3];
    edge_wins = '{3'd7, 3'd0, 3'd1};

    // Directed frames: state after reset is go-back-N, window 1, expecting 0.
    directed_q.push_back(frame_row(3'd0, 8'hFF, 1, 16'h00FF, 1'b1, STATUS_ACCEPTED, 3'd1, 3'd1));
    directed_q.push_back(frame_row(3'd1, 8'h00, 1, 16'hFFFF, 1'b1, STATUS_CHECKSUM_ERR, 3'd1));
    directed_q.push_back(frame_row(3'd5, 8'h10, 1, 16'h0015, 1'b1, STATUS_REJECTED, 3'd1));
    directed_q.push_back(frame_row(3'd1, 8'h80, 3, 16'h0181));
    // Frame two bytes past the maximum length, with a matching checksum.
    directed_q.push_back(frame_row(3'd2, 8'hFF, 257, 16'h0001, 1'b1, STATUS_CHECKSUM_ERR, 3'd2));
    directed_q.push_back(frame_row(3'd2, 8'hFF, 255, 16'hFE03));
    directed_q.push_back(write_row(REG_BUFFERED_MODE, 3'd1));
    directed_q.push_back(write_row(REG_WINDOW_SIZE, 3'd7));
    directed_q.push_back(frame_row(3'd5, 8'h01, 1, 16'h0006));
    directed_q.push_back(frame_row(3'd5, 8'h01, 1, 16'h0006, 1'b1, STATUS_DUPLICATE, 3'd3));
    directed_q.push_back(frame_row(3'd4, 8'h00, 2, 16'h0004));
    // Just below the expected number is the one slot outside a window of seven.
    directed_q.push_back(frame_row(3'd2, 8'h00, 1, 16'h0002, 1'b1, STATUS_REJECTED, 3'd3));
    directed_q.push_back(frame_row(3'd3, 8'h00, 1, 16'h0003));
    directed_q.push_back(frame_row(3'd7, 8'h00, 1, 16'h0007));
    directed_q.push_back(write_row(REG_WINDOW_SIZE, 3'd0));
    directed_q.push_back(frame_row(3'd6, 8'h00, 1, 16'h0006, 1'b1, STATUS_REJECTED, 3'd6));
    directed_q.push_back(write_row(REG_BUFFERED_MODE, 3'd0));
    directed_q.push_back(frame_row(3'd6, 8'h00, 1, 16'h0006, 1'b1, STATUS_ACCEPTED, 3'd7, 3'd1));
    // Flag of frame 7 survives the go-back-N interlude.
    directed_q.push_back(write_row(REG_BUFFERED_MODE, 3'd1));
    directed_q.push_back(write_row(REG_WINDOW_SIZE, 3'd1));
    directed_q.push_back(frame_row(3'd7, 8'h00, 1, 16'h0007, 1'b1, STATUS_DUPLICATE, 3'd7));
    directed_q.push_back(write_row(REG_WINDOW_SIZE, 3'd2));
    directed_q.push_back(frame_row(3'd0, 8'h00, 1, 16'h0000));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_q[r]) begin
      if (directed_q[r].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(directed_q[r].reg_sel, directed_q[r].reg_val);
      end else begin
        for (int k = 1; k <= directed_q[r].nbytes; k++)
          send_byte(directed_q[r].seq, directed_q[r].data, k == directed_q[r].nbytes,
                    directed_q[r].rx, directed_q[r].typed_exp, directed_q[r].want);
      end
    end

    start_bytes = bytes_sent;
    phase = 0;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      wait_drained();
      win = (phase < 3) ? edge_wins[phase] : 3'($urandom_range(0, 7));
      write_reg(REG_BUFFERED_MODE, 3'($urandom_range(0, 3) != 0));
      write_reg(REG_WINDOW_SIZE, win);
      quiet <= (phase == 4) || (phase == 5);
      // A long output hold-off while frames keep coming fills the block up.
      if (phase == 5) hold_req <= hold_req + 1;
      nframes = (win == 3'd0) ? 8 : $urandom_range(15, 40);
      repeat (nframes) send_random_frame();
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes and checked %0d frame statuses across %0d register writes.",
             bytes_sent, results_seen, writes_done);
    $display("Phases covered both modes, window sizes 0 to 7 and a long output hold-off.");
    if (errors == 0 && status_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/swfr_pkg.sv
rtl/core/swfr_regs.sv
rtl/core/swfr_ctrl.sv
rtl/core/swfr_datapath.sv
rtl/core/sliding_window_frame_receiver.sv
dv/testbench.sv
